>>> design/nme_pkg.sv
// Package for the note to MIDI event encoder: event codes, slot layout and duration table.
package nme_pkg;

  // MIDI event bytes and fixed values
  localparam logic [7:0] NOTE_ON_BYTE  = 8'd144;
  localparam logic [7:0] NOTE_OFF_BYTE = 8'd128;
  localparam logic [7:0] OFF_VELOCITY  = 8'd127;
  localparam logic [7:0] DUMMY_NOTE    = 8'd43;
  localparam logic [7:0] ZERO_BYTE     = 8'd0;
  localparam logic [6:0] MAX_NOTE      = 7'd127;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_VELOCITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET  = 1'b1;
  localparam logic [6:0] VELOCITY_RESET = 7'd100;
  localparam logic [6:0] OFFSET_RESET   = 7'd45;

  // Most bytes one request can produce
  localparam int unsigned NUM_SLOTS = 9;
  typedef logic [NUM_SLOTS-1:0][7:0] slot_arr_t;
  typedef logic [NUM_SLOTS-1:0]      slot_mask_t;

  // Duration lookup result
  typedef struct packed {
    logic       hit;
    logic [7:0] d1;
    logic [7:0] d2;
  } dur_t;

  // Map the two duration characters to a one- or two-byte delta time
  function automatic dur_t dur_lookup(input logic [7:0] ca, input logic [7:0] cb_raw);
    dur_t       r;
    logic [7:0] cb;
    cb = (cb_raw == CHAR_NEWLINE) ? CHAR_SPACE : cb_raw;
    r  = '{hit: 1'b1, d1: 8'd0, d2: 8'd0};
    case ({ca, cb})
      {" ", " "}: begin r.d1 = 8'd0;   r.d2 = 8'd0;   end
      {"r", "l"}: begin r.d1 = 8'd134; r.d2 = 8'd78;  end
      {"r", "p"}: begin r.d1 = 8'd133; r.d2 = 8'd80;  end
      {"r", "m"}: begin r.d1 = 8'd132; r.d2 = 8'd88;  end
      {"r", " "}: begin r.d1 = 8'd131; r.d2 = 8'd96;  end
      {"b", "l"}: begin r.d1 = 8'd131; r.d2 = 8'd36;  end
      {"b", "p"}: begin r.d1 = 8'd130; r.d2 = 8'd104; end
      {"b", "m"}: begin r.d1 = 8'd130; r.d2 = 8'd44;  end
      {"b", "t"}: begin r.d1 = 8'd129; r.d2 = 8'd32;  end
      {"b", " "}: begin r.d1 = 8'd129; r.d2 = 8'd112; end
      {"n", "l"}: begin r.d1 = 8'd129; r.d2 = 8'd82;  end
      {"n", "p"}: begin r.d1 = 8'd129; r.d2 = 8'd52;  end
      {"n", "m"}: begin r.d1 = 8'd129; r.d2 = 8'd22;  end
      {"n", "t"}: begin r.d1 = 8'd80;  end
      {"n", " "}: begin r.d1 = 8'd120; end
      {"c", "l"}: begin r.d1 = 8'd97;  end
      {"c", "p"}: begin r.d1 = 8'd90;  end
      {"c", "m"}: begin r.d1 = 8'd67;  end
      {"c", "t"}: begin r.d1 = 8'd40;  end
      {"c", " "}: begin r.d1 = 8'd60;  end
      {"s", "p"}: begin r.d1 = 8'd37;  end
      {"s", "t"}: begin r.d1 = 8'd20;  end
      {"s", " "}: begin r.d1 = 8'd30;  end
      {"f", "t"}: begin r.d1 = 8'd10;  end
      {"f", " "}: begin r.d1 = 8'd15;  end
      {"u", " "}: begin r.d1 = 8'd8;   end
      default:    begin r.hit = 1'b0;  end
    endcase
    return r;
  endfunction

endpackage

>>> design/nme_ifs.sv
// Valid/ready channel interfaces for notes, MIDI bytes and configuration writes.
interface nme_note_if;
  logic       valid;
  logic       ready;
  logic [6:0] pitch;
  logic [7:0] dur_code_a;
  logic [7:0] dur_code_b;
  logic       is_last_note;
  modport source (output valid, pitch, dur_code_a, dur_code_b, is_last_note, input ready);
  modport sink   (input valid, pitch, dur_code_a, dur_code_b, is_last_note, output ready);
endinterface

interface nme_midi_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       bad_code;
  modport source (output valid, out_byte, last_of_run, bad_code, input ready);
  modport sink   (input valid, out_byte, last_of_run, bad_code, output ready);
endinterface

interface nme_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/note_to_midi_event_encoder.sv
// Note to MIDI track event encoder: decodes one note per request into event bytes.
//
//   channel | dir | payload
//   note    | in  | pitch, dur_code_a, dur_code_b, is_last_note
//   midi    | out | out_byte, last_of_run, bad_code
//   cfg     | in  | index (0 velocity, 1 pitch offset), data
//
// A note request is decoded in the cycle it is accepted into a pending burst of
// up to nine byte slots; the output stage sends one byte per cycle while midi is
// ready, so a note yields 7 to 9 bytes, a rest 1, 2, 8 or 9, an unknown code 1 and a
// trailing rest none, and the byte rate of the midi port sets the pace. The next burst
// moves to the output stage as the last byte leaves, with no gap. Reset (rst,
// synchronous) clears the rest flag, both bursts and the registers to velocity
// 100 and offset 45. Stalls on midi hold the bytes.
module note_to_midi_event_encoder
  import nme_pkg::*;
(
  input  logic clk,
  input  logic rst,
  nme_note_if.sink   note,
  nme_midi_if.source midi,
  nme_cfg_if.sink    cfg
);

  logic [6:0] note_velocity;
  logic [6:0] pitch_offset;
  logic       previous_was_rest;
  logic       previous_was_rest_next;

  slot_arr_t  pend_slots;
  slot_mask_t pend_mask;
  logic       pend_bad;
  slot_arr_t  cur_slots;
  slot_mask_t cur_rem;
  logic       cur_bad;

  slot_arr_t  dec_slots;
  slot_mask_t dec_mask;
  logic       dec_bad;
  dur_t       dur;
  logic [7:0] note_sum;
  logic [7:0] note_num;
  logic       pend_valid;
  logic       cur_valid;
  logic       cur_last;
  logic       cur_done;
  logic       load;
  logic       accept;
  slot_mask_t cur_first;
  logic [7:0] cur_byte;

  // Configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      note_velocity <= VELOCITY_RESET;
      pitch_offset  <= OFFSET_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_NOTE_VELOCITY: note_velocity <= cfg.data;
        CFG_PITCH_OFFSET:  pitch_offset  <= cfg.data;
        default:           ;
      endcase
    end
  end

  // Decode the incoming note into byte slots and an enable mask
  always_comb begin
    dur      = dur_lookup(note.dur_code_a, note.dur_code_b);
    note_sum = {1'b0, note.pitch} + {1'b0, pitch_offset};
    note_num = (note_sum > {1'b0, MAX_NOTE}) ? {1'b0, MAX_NOTE} : note_sum;
    dec_slots = '0;
    dec_mask  = '0;
    dec_bad   = 1'b0;
    previous_was_rest_next = previous_was_rest;
    priority if (note.pitch == 7'd0 && note.is_last_note) begin
      // trailing rest: no bytes
      previous_was_rest_next = 1'b0;
    end else if (!dur.hit) begin
      dec_slots[0] = ZERO_BYTE;
      dec_mask     = slot_mask_t'(1);
      dec_bad      = 1'b1;
    end else if (note.pitch == 7'd0) begin
      // rest: dummy note when the previous item was a rest, then the delta
      dec_slots = {dur.d2, dur.d1, OFF_VELOCITY, DUMMY_NOTE, NOTE_OFF_BYTE,
                   ZERO_BYTE, ZERO_BYTE, DUMMY_NOTE, NOTE_ON_BYTE};
      dec_mask  = {dur.d2 != 8'd0, 1'b1, {7{previous_was_rest}}};
      previous_was_rest_next = 1'b1;
    end else begin
      dec_slots = {OFF_VELOCITY, note_num, NOTE_OFF_BYTE, dur.d2, dur.d1,
                   {1'b0, note_velocity}, note_num, NOTE_ON_BYTE, ZERO_BYTE};
      dec_mask  = {3'b111, dur.d2 != 8'd0, 4'b1111, !previous_was_rest};
      previous_was_rest_next = 1'b0;
    end
  end

  // Output stage: lowest remaining slot goes out
  assign cur_valid = cur_rem != '0;
  assign cur_first = cur_rem & (~cur_rem + slot_mask_t'(1));
  assign cur_last  = (cur_rem & (cur_rem - slot_mask_t'(1))) == '0;
  always_comb begin
    cur_byte = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cur_byte = cur_byte | (cur_slots[i] & {8{cur_first[i]}});
    end
  end
  assign midi.valid       = cur_valid;
  assign midi.out_byte    = cur_byte;
  assign midi.last_of_run = cur_last;
  assign midi.bad_code    = cur_bad;

  // Handshake between input, pending burst and output stage
  assign pend_valid = pend_mask != '0;
  assign cur_done   = cur_valid && midi.ready && cur_last;
  assign load       = pend_valid && (!cur_valid || cur_done);
  assign note.ready = !pend_valid || load;
  assign accept     = note.valid && note.ready;

  // Hold the rest flag and the pending burst
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_was_rest <= 1'b0;
      pend_mask         <= '0;
    end else begin
      if (accept) begin
        previous_was_rest <= previous_was_rest_next;
        pend_mask         <= dec_mask;
      end else if (load) begin
        pend_mask <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_slots <= dec_slots;
      pend_bad   <= dec_bad;
    end
  end

  // Advance the output stage: drop the sent slot or load the next burst
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_rem <= '0;
    end else if (load) begin
      cur_rem <= pend_mask;
    end else if (cur_valid && midi.ready) begin
      cur_rem <= cur_rem & ~cur_first;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_slots <= pend_slots;
      cur_bad   <= pend_bad;
    end
  end

  // Checks
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    midi.valid && midi.bad_code |-> midi.last_of_run)
    else $error("bad code byte not last of run");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    midi.valid && midi.ready && !midi.last_of_run |=> midi.valid)
    else $error("burst broke off before its last byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !midi.ready |=> $stable(cur_rem) && $stable(cur_slots))
    else $error("output burst changed under stall");

  a_note_clears_rest: assert property (@(posedge clk) disable iff (rst)
    accept && note.pitch != 7'd0 && dur.hit |=> !previous_was_rest)
    else $error("rest flag set after a note");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !load |=> $stable(pend_mask))
    else $error("pending burst overwritten");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the note to MIDI event encoder: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import nme_pkg::*;

  // One result byte as seen on the midi channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } midi_ev_t;

  // One note request; typed rows carry their byte string left-aligned in bytes
  typedef struct packed {
    logic [6:0]  pitch;
    logic [7:0]  code_a;
    logic [7:0]  code_b;
    logic        last_note;
    logic        typed;
    logic [3:0]  cnt;
    logic        bad;
    logic [71:0] bytes;
  } note_row_t;

  localparam int N_DIRECTED  = 25;
  localparam int N_PHASES    = 4;
  localparam int PHASE_ITEMS = 25;
  localparam int N_CODES     = 26;
  localparam int SETTLE      = 20;

  // Duration codes: first char, second char, delta byte 1, delta byte 2 (0 = none)
  localparam logic [0:N_CODES-1][31:0] DURATIONS = {
    {" ", " ", 8'd0, 8'd0},    {"r", "l", 8'd134, 8'd78}, {"r", "p", 8'd133, 8'd80},
    {"r", "m", 8'd132, 8'd88}, {"r", " ", 8'd131, 8'd96}, {"b", "l", 8'd131, 8'd36},
    {"b", "p", 8'd130, 8'd104}, {"b", "m", 8'd130, 8'd44}, {"b", "t", 8'd129, 8'd32},
    {"b", " ", 8'd129, 8'd112}, {"n", "l", 8'd129, 8'd82}, {"n", "p", 8'd129, 8'd52},
    {"n", "m", 8'd129, 8'd22}, {"n", "t", 8'd80, 8'd0},   {"n", " ", 8'd120, 8'd0},
    {"c", "l", 8'd97, 8'd0},   {"c", "p", 8'd90, 8'd0},   {"c", "m", 8'd67, 8'd0},
    {"c", "t", 8'd40, 8'd0},   {"c", " ", 8'd60, 8'd0},   {"s", "p", 8'd37, 8'd0},
    {"s", "t", 8'd20, 8'd0},   {"s", " ", 8'd30, 8'd0},   {"f", "t", 8'd10, 8'd0},
    {"f", " ", 8'd15, 8'd0},   {"u", " ", 8'd8, 8'd0}
  };

  logic clk = 1'b0;
  logic rst;

  nme_note_if note_ch();
  nme_midi_if midi_ch();
  nme_cfg_if  cfg_ch();

  note_to_midi_event_encoder u_dut (
    .clk  (clk),
    .rst  (rst),
    .note (note_ch),
    .midi (midi_ch),
    .cfg  (cfg_ch)
  );

  // Encoder state mirror
  logic [6:0] note_velocity;
  logic [6:0] pitch_offset;
  logic       prev_rest;

  midi_ev_t   enc_buf [9];
  int         enc_cnt;
  midi_ev_t   midi_expected [$];
  int         mismatches = 0;
  bit         idle_on = 1'b1;

  always #1 clk = ~clk;

  // Append one byte to the encoded burst
  function automatic void emit_byte(input logic [7:0] b);
    enc_buf[enc_cnt] = '{data: b, last: 1'b0, bad: 1'b0};
    enc_cnt++;
  endfunction

  function automatic void emit_delta(input int k);
    emit_byte(DURATIONS[k][15:8]);
    if (DURATIONS[k][7:0] != 8'd0) emit_byte(DURATIONS[k][7:0]);
  endfunction

  // Encode one note into enc_buf and advance the rest flag
  function automatic void encode_note(input logic [6:0] p, input logic [7:0] ca,
                                      input logic [7:0] cb_raw, input logic last_note);
    logic [7:0] cb;
    logic [7:0] num;
    int         hit;
    enc_cnt = 0;
    // trailing rest: nothing out, flag cleared
    if (p == 7'd0 && last_note) begin
      prev_rest = 1'b0;
      return;
    end
    cb = (cb_raw == CHAR_NEWLINE) ? CHAR_SPACE : cb_raw;
    hit = -1;
    for (int k = 0; k < N_CODES; k++) begin
      if (DURATIONS[k][31:16] == {ca, cb}) hit = k;
    end
    // unknown code: single flagged byte, state untouched
    if (hit < 0) begin
      enc_buf[0] = '{data: ZERO_BYTE, last: 1'b1, bad: 1'b1};
      enc_cnt = 1;
      return;
    end
    if (p == 7'd0) begin
      // rest after rest: insert a silent dummy note first
      if (prev_rest) begin
        emit_byte(NOTE_ON_BYTE);
        emit_byte(DUMMY_NOTE);
        emit_byte(ZERO_BYTE);
        emit_byte(ZERO_BYTE);
        emit_byte(NOTE_OFF_BYTE);
        emit_byte(DUMMY_NOTE);
        emit_byte(OFF_VELOCITY);
      end
      emit_delta(hit);
      prev_rest = 1'b1;
    end else begin
      num = {1'b0, p} + {1'b0, pitch_offset};
      if (num > MAX_NOTE) num = {1'b0, MAX_NOTE};
      if (!prev_rest) emit_byte(ZERO_BYTE);
      emit_byte(NOTE_ON_BYTE);
      emit_byte(num);
      emit_byte({1'b0, note_velocity});
      emit_delta(hit);
      emit_byte(NOTE_OFF_BYTE);
      emit_byte(num);
      emit_byte(OFF_VELOCITY);
      prev_rest = 1'b0;
    end
    enc_buf[enc_cnt-1].last = 1'b1;
  endfunction

  // Directed rows; typed rows hold bytes read off by hand for the reset settings
  function automatic note_row_t directed_row(input int i);
    note_row_t r;
    r = '0;
    case (i)
      0:  r = '{7'd0,   "r",   "l",   1'b0, 1'b1, 4'd2, 1'b0, 72'h86_4E_00_00_00_00_00_00_00};
      1:  r = '{7'd1,   "u",   " ",   1'b0, 1'b1, 4'd7, 1'b0, 72'h90_2E_64_08_80_2E_7F_00_00};
      2:  r = '{7'd127, "f",   "t",   1'b0, 1'b1, 4'd8, 1'b0, 72'h00_90_7F_64_0A_80_7F_7F_00};
      3:  r = '{7'd45,  "n",   " ",   1'b0, 1'b1, 4'd8, 1'b0, 72'h00_90_5A_64_78_80_5A_7F_00};
      4:  r = '{7'd0,   "s",   " ",   1'b0, 1'b1, 4'd1, 1'b0, 72'h1E_00_00_00_00_00_00_00_00};
      5:  r = '{7'd0,   "c",   "l",   1'b0, 1'b1, 4'd8, 1'b0, 72'h90_2B_00_00_80_2B_7F_61_00};
      6:  r = '{7'd0,   "x",   "x",   1'b1, 1'b1, 4'd0, 1'b0, 72'h0};
      7:  r = '{7'd82,  "b",   "t",   1'b1, 1'b1, 4'd9, 1'b0, 72'h00_90_7F_64_81_20_80_7F_7F};
      8:  r = '{7'd10,  "z",   "q",   1'b0, 1'b1, 4'd1, 1'b1, 72'h0};
      9:  r = '{7'd5,   "n",   8'h0A, 1'b0, 1'b1, 4'd8, 1'b0, 72'h00_90_32_64_78_80_32_7F_00};
      10: r = '{7'd3,   " ",   " ",   1'b0, 1'b1, 4'd8, 1'b0, 72'h00_90_30_64_00_80_30_7F_00};
      11: r = '{7'd0,   " ",   8'h0A, 1'b0, 1'b1, 4'd1, 1'b0, 72'h0};
      12: r = '{7'd0,   "q",   "q",   1'b0, 1'b1, 4'd1, 1'b1, 72'h0};
      13: r = '{7'd0,   "u",   " ",   1'b0, 1'b0, 4'd0, 1'b0, 72'h0};
      14: r = '{7'd0,   "r",   "m",   1'b1, 1'b1, 4'd0, 1'b0, 72'h0};
      15: r = '{7'd0,   "r",   " ",   1'b0, 1'b1, 4'd2, 1'b0, 72'h83_60_00_00_00_00_00_00_00};
      16: r = '{7'd20,  "r",   "p",   1'b0, 1'b0, 4'd0, 1'b0, 72'h0};
      17: r = '{7'd127, "a",   8'h0A, 1'b1, 1'b1, 4'd1, 1'b1, 72'h0};
      18: r = '{7'd85,  8'hFF, 8'hFF, 1'b0, 1'b1, 4'd1, 1'b1, 72'h0};
      19: r = '{7'd0,   8'h00, 8'h00, 1'b0, 1'b1, 4'd1, 1'b1, 72'h0};
      20: r = '{7'd64,  "n",   "m",   1'b0, 1'b0, 4'd0, 1'b0, 72'h0};
      21: r = '{7'd0,   "b",   "l",   1'b0, 1'b0, 4'd0, 1'b0, 72'h0};
      22: r = '{7'd0,   "b",   "p",   1'b0, 1'b0, 4'd0, 1'b0, 72'h0};
      23: r = '{7'd0,   "c",   " ",   1'b1, 1'b1, 4'd0, 1'b0, 72'h0};
      default: r = '{7'd100, "s", "p", 1'b0, 1'b0, 4'd0, 1'b0, 72'h0};
    endcase
    return r;
  endfunction

  // Send one note request, record its bytes, maybe hold off afterwards
  task automatic send_note(input note_row_t row);
    note_ch.valid        <= 1'b1;
    note_ch.pitch        <= row.pitch;
    note_ch.dur_code_a   <= row.code_a;
    note_ch.dur_code_b   <= row.code_b;
    note_ch.is_last_note <= row.last_note;
    @(posedge clk);
    while (!note_ch.ready) @(posedge clk);
    encode_note(row.pitch, row.code_a, row.code_b, row.last_note);
    if (row.typed) begin
      for (int i = 0; i < row.cnt; i++) begin
        midi_expected.push_back('{data: row.bytes[71-8*i -: 8],
                                  last: (i == row.cnt - 1), bad: row.bad});
      end
    end else begin
      for (int i = 0; i < enc_cnt; i++) midi_expected.push_back(enc_buf[i]);
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      note_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Drop valid, drain all bytes, then let a trailing rest settle
  task automatic drain_notes();
    note_ch.valid <= 1'b0;
    while (midi_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [6:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_NOTE_VELOCITY) note_velocity = value;
    else pitch_offset = value;
  endtask

  // Stall the midi channel in random bursts while idling is on
  initial begin
    midi_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
        midi_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        midi_ch.ready <= 1'b1;
      end
    end
  end

  // Check each accepted byte against the oldest expectation
  always @(posedge clk) begin : check_midi
    midi_ev_t want;
    if (!rst && midi_ch.valid && midi_ch.ready) begin
      if (midi_expected.size() == 0) begin
        $error("out_byte: no byte expected, got %0h", midi_ch.out_byte);
        mismatches = mismatches + 1;
      end else begin
        want = midi_expected.pop_front();
        if (midi_ch.out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, midi_ch.out_byte);
          mismatches = mismatches + 1;
        end
        if (midi_ch.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, midi_ch.last_of_run);
          mismatches = mismatches + 1;
        end
        if (midi_ch.bad_code !== want.bad) begin
          $error("bad_code: expected %0b, got %0b", want.bad, midi_ch.bad_code);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // Stimulus: directed rows at reset settings, then random phases
  initial begin
    note_row_t  row;
    int         k;
    logic [6:0] vel;
    logic [6:0] ofs;
    rst                  <= 1'b1;
    note_ch.valid        <= 1'b0;
    note_ch.pitch        <= '0;
    note_ch.dur_code_a   <= '0;
    note_ch.dur_code_b   <= '0;
    note_ch.is_last_note <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_NOTE_VELOCITY;
    cfg_ch.data          <= '0;
    note_velocity = VELOCITY_RESET;
    pitch_offset  = OFFSET_RESET;
    prev_rest     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_note(directed_row(i));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_notes();
      vel = (ph == 0) ? 7'd127 : (ph == 1) ? 7'd0 : 7'(($urandom_range(0, 127)));
      ofs = (ph == 0) ? 7'd0 : (ph == 1) ? 7'd127 : 7'(($urandom_range(0, 127)));
      write_cfg(CFG_NOTE_VELOCITY, vel);
      write_cfg(CFG_PITCH_OFFSET, ofs);
      cfg_ch.valid <= 1'b0;
      // no idling in the closing phase
      idle_on = (ph != N_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        row = '0;
        if ($urandom_range(0, 9) < 8) begin
          // well-formed note or rest with a table code
          k = $urandom_range(0, N_CODES - 1);
          row.code_a = DURATIONS[k][31:24];
          row.code_b = DURATIONS[k][23:16];
          if (row.code_b == CHAR_SPACE && $urandom_range(0, 1) == 1) row.code_b = CHAR_NEWLINE;
          row.pitch = ($urandom_range(0, 99) < 35) ? 7'd0 : 7'($urandom_range(1, 127));
          row.last_note = ($urandom_range(0, 19) == 0);
        end else begin
          // noise: arbitrary characters
          row.code_a    = 8'($urandom_range(0, 255));
          row.code_b    = 8'($urandom_range(0, 255));
          row.pitch     = 7'($urandom_range(0, 127));
          row.last_note = 1'($urandom_range(0, 1));
        end
        send_note(row);
      end
    end

    drain_notes();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> note_to_midi_event_encoder.f
design/nme_pkg.sv
design/nme_ifs.sv
design/note_to_midi_event_encoder.sv
tb/tb_top.sv
